/* hw/rtl/esd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types and constants of the elevator scan dispatcher.
// ----------------------------------------------------------------------------
package esd_pkg;

   localparam int NUM_FLOORS = 9;
   localparam int FLOOR_W    = (NUM_FLOORS > 1) ? $clog2(NUM_FLOORS) : 1;
   localparam int CALL_W     = 4;
   localparam int FLOOR_OUT_W = 4;
   localparam int PEND_W     = 9;

   localparam logic REQ_PRESS = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   typedef enum logic [1:0] {
      MOTOR_STOP = 2'd0,
      MOTOR_UP   = 2'd1,
      MOTOR_DOWN = 2'd2
   } esd_motor_type;

   typedef enum logic [1:0] {
      EVT_NONE   = 2'd0,
      EVT_DEPART = 2'd1,
      EVT_ARRIVE = 2'd2,
      EVT_SERVED = 2'd3
   } esd_event_type;

   typedef struct packed {
      logic              req_type;
      logic [CALL_W-1:0] call_floor;
   } esd_req_beat_type;

   typedef struct packed {
      logic [FLOOR_OUT_W-1:0] floor_now;
      logic                   going_up;
      logic [1:0]             motor_cmd;
      logic [1:0]             event_code;
      logic [PEND_W-1:0]      pending_mask;
   } esd_rsp_beat_type;

endpackage

/* hw/rtl/elevator_scan_dispatch.sv */
`timescale 1ns / 1ps
// A request beat is held in the input register, then its result in the result
// register. Throughput: one beat per cycle unless rsp_ready stalls; the input
// register refills as it empties, and the car state updates as the result register loads.
// Reset: synchronous; clears both stage valids, all pending calls, floor 0,
// direction up, car stopped.
// ----------------------------------------------------------------------------
// elevator_scan_dispatch
// Single-car LOOK dispatcher: input register, dispatch logic, result register.
// ----------------------------------------------------------------------------
module elevator_scan_dispatch
   import esd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  esd_req_beat_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output esd_rsp_beat_type rsp_data
);

   logic             stage_valid, stage_take;
   esd_req_beat_type stage_data;
   esd_rsp_beat_type result;
   logic             rsp_valid_ff, rsp_valid_in;
   esd_rsp_beat_type rsp_data_ff;

   assign stage_take = stage_valid && (!rsp_valid_ff || rsp_ready);

   esd_req_stage u_req_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .stage_take  (stage_take),
      .stage_valid (stage_valid),
      .stage_data  (stage_data)
   );

   esd_dispatch_core u_core (
      .clock     (clock),
      .reset     (reset),
      .item_fire (stage_take),
      .item_data (stage_data),
      .result    (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_in = stage_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_take) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hw/rtl/esd_req_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_req_stage
// Input register: captures one request beat and holds it until the
// dispatch stage takes it.
// ----------------------------------------------------------------------------
module esd_req_stage
   import esd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  esd_req_beat_type req_data,
   input  logic             stage_take,
   output logic             stage_valid,
   output esd_req_beat_type stage_data
);

   logic             valid_ff, valid_in;
   esd_req_beat_type data_ff;

   assign req_ready   = !valid_ff || stage_take;
   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

endmodule

/* hw/rtl/esd_dispatch_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_dispatch_core
// Car state registers and the single-pass LOOK direction and stop logic.
// ----------------------------------------------------------------------------
module esd_dispatch_core
   import esd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             item_fire,
   input  esd_req_beat_type item_data,
   output esd_rsp_beat_type result
);

   logic [NUM_FLOORS-1:0] req_bits_ff, req_bits_in;
   logic [FLOOR_W-1:0]    floor_ff, floor_in;
   logic                  dir_up_ff, dir_up_in;
   logic                  moving_ff, moving_in;

   logic [NUM_FLOORS-1:0] ge_mask, le_mask, press_bit;
   logic                  any_ge, any_le, stop_tick;
   esd_event_type         evt;
   esd_motor_type         motor;
   logic [FLOOR_W+FLOOR_OUT_W-1:0] floor_ext;
   logic [NUM_FLOORS+PEND_W-1:0]   pend_ext;

   always_comb begin
      for (int i = 0; i < NUM_FLOORS; i++) begin
         ge_mask[i]   = FLOOR_W'(i) >= floor_ff;
         le_mask[i]   = FLOOR_W'(i) <= floor_ff;
         press_bit[i] = int'(item_data.call_floor) == i;
      end
   end

   assign any_ge = |(req_bits_ff & ge_mask);
   assign any_le = |(req_bits_ff & le_mask);

   always_comb begin
      req_bits_in = req_bits_ff;
      floor_in    = floor_ff;
      dir_up_in   = dir_up_ff;
      moving_in   = moving_ff;
      stop_tick   = 1'b0;
      evt         = EVT_NONE;
      if (item_data.req_type == REQ_PRESS) begin
         req_bits_in = req_bits_ff | press_bit;
      end else if (!moving_ff) begin
         if (req_bits_ff == '0) begin
            stop_tick = 1'b1;
         end else begin
            if (dir_up_in && !any_ge) begin
               dir_up_in = 1'b0;
            end
            if (!dir_up_in && !any_le) begin
               dir_up_in = 1'b1;
               stop_tick = 1'b1;
            end
         end
         if (!stop_tick) begin
            if (req_bits_ff[floor_ff]) begin
               req_bits_in[floor_ff] = 1'b0;
               evt = EVT_SERVED;
            end else begin
               moving_in = 1'b1;
               evt = EVT_DEPART;
            end
         end
      end else begin
         if (dir_up_ff) begin
            if (floor_ff != FLOOR_W'(NUM_FLOORS - 1)) begin
               floor_in = floor_ff + 1'b1;
            end
         end else if (floor_ff != '0) begin
            floor_in = floor_ff - 1'b1;
         end
         if (req_bits_ff[floor_in]) begin
            req_bits_in[floor_in] = 1'b0;
            moving_in = 1'b0;
            evt = EVT_ARRIVE;
         end
      end
   end

   always_comb begin
      if (!moving_in) begin
         motor = MOTOR_STOP;
      end else if (dir_up_in) begin
         motor = MOTOR_UP;
      end else begin
         motor = MOTOR_DOWN;
      end
   end

   assign floor_ext = {{FLOOR_OUT_W{1'b0}}, floor_in};
   assign pend_ext  = {{PEND_W{1'b0}}, req_bits_in};

   assign result.floor_now    = floor_ext[FLOOR_OUT_W-1:0];
   assign result.going_up     = dir_up_in;
   assign result.motor_cmd    = motor;
   assign result.event_code   = evt;
   assign result.pending_mask = pend_ext[PEND_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         req_bits_ff <= '0;
         floor_ff    <= '0;
         dir_up_ff   <= 1'b1;
         moving_ff   <= 1'b0;
      end else if (item_fire) begin
         req_bits_ff <= req_bits_in;
         floor_ff    <= floor_in;
         dir_up_ff   <= dir_up_in;
         moving_ff   <= moving_in;
      end
   end

endmodule

/* hw/rtl/esd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_checker
// Port-level checks of the elevator scan dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
module esd_checker
   import esd_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input esd_req_beat_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input esd_rsp_beat_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stop_events: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_code == EVT_ARRIVE || rsp_data.event_code == EVT_SERVED)
      |-> rsp_data.motor_cmd == MOTOR_STOP)
      else $error("motor running on a stop event");

   a_depart_runs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_code == EVT_DEPART
      |-> (rsp_data.going_up ? rsp_data.motor_cmd == MOTOR_UP
                             : rsp_data.motor_cmd == MOTOR_DOWN))
      else $error("departure without matching motor drive");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request beat dropped or changed while stalled");

endmodule

bind elevator_scan_dispatch esd_checker u_esd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
